@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the unpacker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/paeu_pkg.sv @@
// Types, constants and command/status structs of the packed ADC event unpacker.
package paeu_pkg;

    localparam int NUM_GROUPS        = 8;
    localparam int MAX_SAMPLES       = 4096;
    localparam int CH_PER_GROUP      = 8;
    localparam int SAMPLES_PER_BLOCK = 3;
    localparam int FIELD_W           = 12;
    localparam int SPC_W             = 13;

    localparam logic [SPC_W-1:0] SPC_RESET  = 13'd1023;
    localparam logic [3:0]       SIG_VALUE  = 4'hA;
    localparam logic [7:0]       GROUP_MASK = 8'((1 << NUM_GROUPS) - 1);

    localparam logic [1:0] ST_SAMPLE   = 2'd0;
    localparam logic [1:0] ST_BAD_SIG  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [31:0] data_word;
        logic        first_word;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  channel;
        logic [11:0] sample_index;
        logic [11:0] sample_value;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       load_header;
        logic       load_mask;
        logic       start_data;
        logic       load_word;
        logic       step;
        logic       emit_err;
        logic [1:0] err_status;
    } t_cmd;

    typedef struct packed {
        logic sig_ok;
        logic hdr_ok;
        logic out_free;
        logic field_fin;
        logic event_done;
        logic last_field;
    } t_sts;

endpackage

@@ rtl/core/packed_adc_event_unpacker_top.sv @@
// Top level of the packed ADC event unpacker.
// Header words are parsed as they are accepted; a data word is loaded and then unpacked by
// the field step loop, one step per completed 12-bit field (2 or 3), with input stalled meanwhile.
// A sample is registered in the output register at its field step and is held there while the receiver stalls.
// Synchronous active-low reset clears the parser to idle and the register to 1023.
module packed_adc_event_unpacker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [paeu_pkg::SPC_W-1:0]    i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  paeu_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output paeu_pkg::t_out_item           o_out_item
);

    paeu_pkg::t_cmd cmd;
    paeu_pkg::t_sts sts;
    logic           in_ready;

    assign o_in_stall = !in_ready;

    paeu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_first_word (i_in_item.first_word),
        .o_in_ready   (in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    paeu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

@@ rtl/core/paeu_ctrl.sv @@
// Event parsing state machine of the unpacker.
`include "assert_macros.svh"

module paeu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_first_word,
    output logic            o_in_ready,
    input  paeu_pkg::t_sts  i_sts,
    output paeu_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_HDR_MASK  = 3'd1;
    localparam logic [2:0] S_HDR_SKIP2 = 3'd2;
    localparam logic [2:0] S_HDR_SKIP3 = 3'd3;
    localparam logic [2:0] S_DATA      = 3'd4;
    localparam logic [2:0] S_UNPACK    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_acc;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state != S_UNPACK) && i_sts.out_free;
        in_acc     = i_in_valid && o_in_ready;
        if (in_acc) begin
            if (i_first_word) begin
                if (!i_sts.sig_ok) begin
                    o_cmd.emit_err   = 1'b1;
                    o_cmd.err_status = paeu_pkg::ST_BAD_SIG;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.load_header = 1'b1;
                    n_state           = S_HDR_MASK;
                end
            end else begin
                unique case (r_state)
                    S_HDR_MASK: begin
                        o_cmd.load_mask = 1'b1;
                        if (!i_sts.hdr_ok) begin
                            o_cmd.emit_err   = 1'b1;
                            o_cmd.err_status = paeu_pkg::ST_MISMATCH;
                            n_state          = S_IDLE;
                        end else begin
                            n_state = S_HDR_SKIP2;
                        end
                    end
                    S_HDR_SKIP2: begin
                        n_state = S_HDR_SKIP3;
                    end
                    S_HDR_SKIP3: begin
                        o_cmd.start_data = 1'b1;
                        n_state          = S_DATA;
                    end
                    S_DATA: begin
                        o_cmd.load_word = 1'b1;
                        n_state         = S_UNPACK;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_state == S_UNPACK && i_sts.out_free) begin
            o_cmd.step = 1'b1;
            if (i_sts.field_fin || i_sts.event_done) begin
                n_state = S_IDLE;
            end else if (i_sts.last_field) begin
                n_state = S_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_ALWAYS(a_step_needs_slot, i_clk, i_rst_n, o_cmd.step |-> i_sts.out_free, "field step with output slot busy")
    `ASSERT_NEXT(a_err_goes_idle, i_clk, i_rst_n, o_cmd.emit_err, r_state == S_IDLE, "error did not end the event")
    `ASSERT_NEXT(a_word_unpacks, i_clk, i_rst_n, o_cmd.load_word, r_state == S_UNPACK, "loaded word not unpacked")

endmodule

@@ rtl/core/paeu_dp.sv @@
// Datapath of the unpacker: header check, bit buffer, field counters, output register.
`include "assert_macros.svh"

module paeu_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  paeu_pkg::t_in_item            i_in_item,
    input  logic                          i_cfg_wr_en,
    input  logic [paeu_pkg::SPC_W-1:0]    i_cfg_wr_data,
    input  paeu_pkg::t_cmd                i_cmd,
    output paeu_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output paeu_pkg::t_out_item           o_out_item
);

    function automatic logic [2:0] f_lowest(input logic [7:0] m);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    logic [paeu_pkg::SPC_W-1:0] r_spc;
    logic [27:0]                r_event_words;
    logic [7:0]                 r_mask;
    logic [2:0]                 r_group;
    logic [2:0]                 r_ch;
    logic [1:0]                 r_sub;
    logic [11:0]                r_base;
    logic [39:0]                r_bits;
    logic [5:0]                 r_avail;
    logic                       r_out_valid;
    paeu_pkg::t_out_item        r_out_item;

    logic [31:0] word;
    logic [7:0]  mask_in;
    logic [3:0]  groups;
    logic [27:0] ew_m4;
    logic [24:0] blocks;
    logic [15:0] n3;
    logic [15:0] qlo_sum;
    logic [15:0] qhi_sum;
    logic [12:0] qlo;
    logic [12:0] qhi1;
    logic [16:0] lo_prod;
    logic [16:0] hi_prod;
    logic        cnt_ok;

    logic [12:0] s;
    logic        emit;
    logic [7:0]  above;
    logic        has_next;
    logic        last_ch;
    logic        blk_end;
    logic [12:0] base3;
    logic        grp_end;
    logic        fin;

    // expected count check: floor(8*q/3) == n with q = floor(blocks/groups)
    // becomes qlo*groups <= blocks < (qhi+1)*groups
    always_comb begin
        word    = i_in_item.data_word;
        mask_in = word[7:0] & paeu_pkg::GROUP_MASK;
        groups  = '0;
        for (int g = 0; g < 8; g++) begin
            groups = groups + 4'(mask_in[g]);
        end
        ew_m4   = r_event_words - 28'd4;
        blocks  = ew_m4[27:3];
        n3      = 16'(r_spc) + 16'({r_spc, 1'b0});
        qlo_sum = n3 + 16'd7;
        qhi_sum = n3 + 16'd2;
        qlo     = qlo_sum[15:3];
        qhi1    = qhi_sum[15:3] + 13'd1;
        lo_prod = 17'(qlo) * 17'(groups);
        hi_prod = 17'(qhi1) * 17'(groups);
        cnt_ok  = (r_event_words >= 28'd4) && (groups != 4'd0) && (r_spc != '0)
                  && (int'(r_spc) <= paeu_pkg::MAX_SAMPLES);
    end

    always_comb begin
        s        = 13'(r_base) + 13'(r_sub);
        emit     = s < r_spc;
        above    = r_mask & (8'hFF << (4'(r_group) + 4'd1));
        has_next = |above;
        last_ch  = r_ch == 3'(paeu_pkg::CH_PER_GROUP - 1);
        blk_end  = last_ch && (r_sub == 2'(paeu_pkg::SAMPLES_PER_BLOCK - 1));
        base3    = 13'(r_base) + 13'(paeu_pkg::SAMPLES_PER_BLOCK);
        grp_end  = blk_end && (base3 >= r_spc);
        fin      = emit && last_ch && (s == r_spc - 13'd1) && !has_next;
    end

    assign o_sts.sig_ok     = word[31:28] == paeu_pkg::SIG_VALUE;
    assign o_sts.hdr_ok     = cnt_ok && (25'(lo_prod) <= blocks) && (blocks < 25'(hi_prod));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_sts.field_fin  = fin;
    assign o_sts.event_done = grp_end && !has_next;
    assign o_sts.last_field = r_avail < 6'(2 * paeu_pkg::FIELD_W);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc       <= paeu_pkg::SPC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_spc <= i_cfg_wr_data;
            end
            if (i_cmd.emit_err || (i_cmd.step && emit)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_header) begin
            r_event_words <= word[27:0];
        end
        if (i_cmd.load_mask) begin
            r_mask <= mask_in;
        end
        if (i_cmd.start_data) begin
            r_group <= f_lowest(r_mask);
            r_ch    <= '0;
            r_sub   <= '0;
            r_base  <= '0;
            r_bits  <= '0;
            r_avail <= '0;
        end else if (i_cmd.load_word) begin
            r_bits  <= ({8'd0, word} << r_avail[3:0]) | {32'd0, r_bits[7:0]};
            r_avail <= r_avail + 6'd32;
        end else if (i_cmd.step) begin
            r_bits  <= r_bits >> paeu_pkg::FIELD_W;
            r_avail <= r_avail - 6'(paeu_pkg::FIELD_W);
            if (blk_end) begin
                r_ch  <= '0;
                r_sub <= '0;
                if (grp_end) begin
                    r_base  <= '0;
                    r_group <= f_lowest(above);
                end else begin
                    r_base <= base3[11:0];
                end
            end else if (r_sub == 2'(paeu_pkg::SAMPLES_PER_BLOCK - 1)) begin
                r_sub <= '0;
                r_ch  <= r_ch + 3'd1;
            end else begin
                r_sub <= r_sub + 2'd1;
            end
        end

        if (i_cmd.emit_err) begin
            r_out_item.channel      <= '0;
            r_out_item.sample_index <= '0;
            r_out_item.sample_value <= '0;
            r_out_item.status       <= i_cmd.err_status;
            r_out_item.last         <= 1'b1;
        end else if (i_cmd.step && emit) begin
            r_out_item.channel      <= {r_group, r_ch};
            r_out_item.sample_index <= s[11:0];
            r_out_item.sample_value <= r_bits[paeu_pkg::FIELD_W-1:0];
            r_out_item.status       <= paeu_pkg::ST_SAMPLE;
            r_out_item.last         <= fin;
        end
    end

    `ASSERT_ALWAYS(a_carry_short, i_clk, i_rst_n, i_cmd.load_word |-> (r_avail < 6'(paeu_pkg::FIELD_W)), "carry holds a whole field at word load")
    `ASSERT_ALWAYS(a_step_has_field, i_clk, i_rst_n, i_cmd.step |-> (r_avail >= 6'(paeu_pkg::FIELD_W)), "field step without enough bits")

endmodule

@@ dv/paeu_checker.sv @@
// Checker for the packed ADC event unpacker: predicts and scores every output item.
`timescale 1ns / 1ps

module paeu_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [paeu_pkg::SPC_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  paeu_pkg::t_in_item         i_in_item,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  paeu_pkg::t_out_item        i_out_item,
    output int                         o_fail_count,
    output int                         o_pending
);
    import paeu_pkg::*;

    localparam int FIELDS_PER_BLOCK = 24;

    typedef enum logic [1:0] {PARSE_IDLE, PARSE_HEADER, PARSE_DATA} t_parse;

    t_parse           parse_ph;
    logic [SPC_W-1:0] spc;
    logic [1:0]       hdr_cnt;
    logic [27:0]      evt_words;
    logic [7:0]       grp_en;
    int               cur_grp;
    int               field_idx;
    int               sample_base;
    logic [7:0]       carry;
    int               carry_n;
    t_out_item        sample_q[$];
    int               fails = 0;

    task automatic reset_model();
        spc         = SPC_RESET;
        parse_ph    = PARSE_IDLE;
        hdr_cnt     = 2'd0;
        evt_words   = 28'd0;
        grp_en      = 8'd0;
        cur_grp     = 0;
        field_idx   = 0;
        sample_base = 0;
        carry       = 8'd0;
        carry_n     = 0;
        sample_q.delete();
    endtask

    function automatic int next_enabled(input int from);
        for (int g = from; g < NUM_GROUPS; g++) begin
            if (grp_en[g]) begin
                return g;
            end
        end
        return NUM_GROUPS;
    endfunction

    task automatic queue_result(input logic [5:0] ch, input logic [11:0] idx,
                                input logic [11:0] val, input logic [1:0] st,
                                input logic lst);
        t_out_item r;
        r.channel      = ch;
        r.sample_index = idx;
        r.sample_value = val;
        r.status       = st;
        r.last         = lst;
        sample_q.push_back(r);
    endtask

    task automatic unpack_word(input t_in_item word_in);
        logic [63:0]     bits;
        int              avail;
        int              f;
        int              ch;
        int              s;
        int              ngrp;
        int              n;
        longint unsigned per_ch;
        bit              ok;
        bit              fin;
        n = int'(spc);
        if (word_in.first_word) begin
            if (word_in.data_word[31:28] != SIG_VALUE) begin
                parse_ph = PARSE_IDLE;
                queue_result(6'd0, 12'd0, 12'd0, ST_BAD_SIG, 1'b1);
            end else begin
                evt_words = word_in.data_word[27:0];
                hdr_cnt   = 2'd1;
                parse_ph  = PARSE_HEADER;
            end
        end else if (parse_ph == PARSE_HEADER) begin
            if (hdr_cnt == 2'd1) begin
                grp_en = word_in.data_word[7:0] & GROUP_MASK;
                ngrp   = $countones(grp_en);
                ok     = evt_words >= 28'd4 && ngrp != 0 && n != 0 && n <= MAX_SAMPLES;
                if (ok) begin
                    per_ch = 64'(evt_words - 28'd4) / 64'(ngrp * CH_PER_GROUP);
                    ok     = (per_ch * 64'd32 / 64'd12 == 64'(n));
                end
                if (!ok) begin
                    parse_ph = PARSE_IDLE;
                    queue_result(6'd0, 12'd0, 12'd0, ST_MISMATCH, 1'b1);
                end else begin
                    hdr_cnt = 2'd2;
                end
            end else if (hdr_cnt == 2'd2) begin
                hdr_cnt = 2'd3;
            end else begin
                cur_grp     = next_enabled(0);
                field_idx   = 0;
                sample_base = 0;
                carry       = 8'd0;
                carry_n     = 0;
                parse_ph    = PARSE_DATA;
            end
        end else if (parse_ph == PARSE_DATA) begin
            bits  = {56'd0, carry} | ({32'd0, word_in.data_word} << carry_n);
            avail = carry_n + 32;
            while (avail >= FIELD_W) begin
                f  = field_idx;
                ch = f / SAMPLES_PER_BLOCK;
                s  = sample_base + f % SAMPLES_PER_BLOCK;
                if (s < n) begin
                    fin = ch == CH_PER_GROUP - 1 && s == n - 1 &&
                          next_enabled(cur_grp + 1) >= NUM_GROUPS;
                    queue_result(6'(cur_grp * CH_PER_GROUP + ch), 12'(s), bits[11:0],
                                 ST_SAMPLE, fin);
                    if (fin) begin
                        parse_ph = PARSE_IDLE;
                        return;
                    end
                end
                bits      = bits >> FIELD_W;
                avail     = avail - FIELD_W;
                field_idx = f + 1;
                if (field_idx >= FIELDS_PER_BLOCK) begin
                    field_idx   = 0;
                    sample_base = sample_base + SAMPLES_PER_BLOCK;
                    if (sample_base >= n) begin
                        sample_base = 0;
                        cur_grp     = next_enabled(cur_grp + 1);
                        if (cur_grp >= NUM_GROUPS) begin
                            cur_grp  = 0;
                            parse_ph = PARSE_IDLE;
                            return;
                        end
                    end
                end
            end
            carry   = bits[7:0];
            carry_n = avail;
        end
    endtask

    task automatic score(input t_out_item got);
        t_out_item want;
        if (sample_q.size() == 0) begin
            $error("unexpected output item: channel %0d sample_index %0d status %0d",
                   got.channel, got.sample_index, got.status);
            fails++;
        end else begin
            want = sample_q.pop_front();
            if (got.channel !== want.channel) begin
                $error("channel: expected %0d, got %0d", want.channel, got.channel);
                fails++;
            end
            if (got.sample_index !== want.sample_index) begin
                $error("sample_index: expected %0d, got %0d",
                       want.sample_index, got.sample_index);
                fails++;
            end
            if (got.sample_value !== want.sample_value) begin
                $error("sample_value: expected %0d, got %0d",
                       want.sample_value, got.sample_value);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        end
    endtask

    // outputs are scored before inputs: a result never belongs to an item taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                score(i_out_item);
            end
            if (i_cfg_wr_en) begin
                spc = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                unpack_word(i_in_item);
            end
        end
        o_fail_count <= fails;
        o_pending    <= sample_q.size();
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: feeds event words and register writes to the unpacker and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import paeu_pkg::*;

    localparam int RUN_LIMIT     = 300000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 100;
    localparam int RANDOM_PHASES = 4;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [SPC_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    t_in_item         in_item     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    t_out_item        out_item;

    int   fail_count;
    int   pending;
    int   cycles      = 0;
    int   spc_now     = int'(SPC_RESET);
    int   words_sent  = 0;
    logic quiet       = 1'b0;
    logic hold_req    = 1'b0;
    bit   hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   spc_opts[9] = '{2, 5, 8, 10, 13, 16, 18, 21, 24};

    packed_adc_event_unpacker_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item)
    );

    paeu_checker u_scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !quiet && ($urandom_range(99) < 13);
        end
    end

    task automatic send_word(input logic [31:0] w, input logic first);
        while (!quiet && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid             <= 1'b1;
        in_item.data_word    <= w;
        in_item.first_word   <= first;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] bad_sig_word();
        logic [3:0] sig;
        sig = 4'($urandom_range(15));
        if (sig == SIG_VALUE) begin
            sig = 4'h0;
        end
        return {sig, 28'($urandom)};
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // bad signature word parks the parser before the register changes
    task automatic write_spc(input logic [SPC_W-1:0] v);
        send_word(bad_sig_word(), 1'b1);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        spc_now = int'(v);
    endtask

    function automatic int words_per_chan(input int spc);
        for (int w = 0; w <= 1600; w++) begin
            if (w * 32 / 12 == spc) begin
                return w;
            end
        end
        return -1;
    endfunction

    task automatic send_event(input logic [7:0] mask, input int data_words, input bit size_ok,
                              input bit use_fill, input logic [31:0] fill);
        int          groups;
        int          w;
        int          size;
        logic [31:0] d;
        groups = $countones(mask);
        w      = words_per_chan(spc_now);
        if (size_ok && groups != 0 && w >= 0) begin
            size = 4 + groups * 8 * w + $urandom_range(groups * 8 - 1);
        end else begin
            size = $urandom_range(300);
        end
        send_word({SIG_VALUE, 28'(size)}, 1'b1);
        d      = $urandom;
        d[7:0] = mask;
        send_word(d, 1'b0);
        send_word($urandom, 1'b0);
        send_word($urandom, 1'b0);
        for (int i = 0; i < data_words; i++) begin
            send_word(use_fill ? fill : 32'($urandom), 1'b0);
        end
        words_sent += 4 + data_words;
    endtask

    task automatic random_event();
        int         pick;
        int         ng;
        int         full;
        logic [7:0] mask;
        pick = $urandom_range(99);
        ng   = ($urandom_range(9) == 0) ? 3 : (($urandom_range(3) == 0) ? 2 : 1);
        mask = 8'h00;
        repeat (ng) mask[$urandom_range(7)] = 1'b1;
        full = $countones(mask) * ((spc_now + 2) / 3) * 9;
        if (pick < 70) begin
            send_event(mask, full, 1'b1, 1'b0, 32'h0);
            repeat ($urandom_range(2)) send_word($urandom, 1'b0);
        end else if (pick < 80) begin
            send_event(mask, $urandom_range(full - 1), 1'b1, 1'b0, 32'h0);
        end else if (pick < 88) begin
            send_event(($urandom_range(3) == 0) ? 8'h00 : mask, $urandom_range(6),
                       1'($urandom_range(1)), 1'b0, 32'h0);
        end else if (pick < 94) begin
            send_word(bad_sig_word(), 1'b1);
        end else begin
            repeat ($urandom_range(1, 4)) send_word($urandom, 1'b0);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register at reset value: no size can match
        send_word(32'h0000_0000, 1'b1);
        send_word({SIG_VALUE, 28'd0}, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);

        write_spc(SPC_W'(2));
        send_event(8'h80, 9, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_word(32'h0000_0000, 1'b0);
        send_word({SIG_VALUE, 28'd100}, 1'b1);
        send_word(32'hFFFF_FF00, 1'b0);
        send_event(8'h01, 3, 1'b1, 1'b1, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 1'b1);

        words_sent = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_spc(SPC_W'(p == 0 ? 2 : spc_opts[$urandom_range(8)]));
            if (p == 1) begin
                hold_req <= 1'b1;
            end
            quiet <= (p == 2);
            while (words_sent < (p + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
                random_event();
            end
        end
        quiet <= 1'b0;

        // register extremes
        write_spc(SPC_W'(MAX_SAMPLES));
        send_event(8'h01, 4, 1'b1, 1'b0, 32'h0);
        send_event(8'hFF, 3, 1'b1, 1'b0, 32'h0);
        write_spc(SPC_W'(0));
        send_event(8'h04, 2, 1'b1, 1'b0, 32'h0);
        write_spc(13'h1FFF);
        send_event(8'h10, 2, 1'b1, 1'b0, 32'h0);
        write_spc(SPC_W'(3));
        send_event(8'h02, 9, 1'b1, 1'b0, 32'h0);
        write_spc(SPC_W'(18));
        send_event(8'h40, 54, 1'b1, 1'b0, 32'h0);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
